// ----- design/tnt_pkg.sv -----
// Package for the triangle normal and tangent core.
// Holds widths and the coordinate types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tnt_pkg;
  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 36;
  localparam int RedW   = 30;
  localparam int OpW    = RedW + 1;
  localparam int SumW   = 2 * OpW;
  localparam int LenW   = 31;
  localparam int NumW   = RedW + 16;
  localparam int OneQ14 = 16384;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
endpackage
`default_nettype wire

// ----- design/triangle_normal_tangent_core.sv -----
// Triangle normal and tangent core: top level with its sequencer and shared datapath.
// Depends on tnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Vertices enter one request at a time. The first two vertices of a triangle are
// only latched. The third vertex starts the sequencer, which builds the cross
// product, uv determinant and tangent with one shared 31x31 signed multiplier
// (one product per cycle), then normalises each vector: a reduction below 2^30,
// squares of its components on the same multiplier, a bit-serial square root
// and a restoring divider (one load step plus 46 quotient steps per component).
// A zero normal or zero determinant skips both normalisations, a zero tangent
// skips its own. in_stall stays high while the sequencer runs, and a third
// vertex is also refused while a result still waits. The result is held in an
// output register until taken, while the first vertex of the next triangle may
// already be accepted.
module triangle_normal_tangent_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire tnt_pkg::coord_t pos_x,
  input  wire tnt_pkg::coord_t pos_y,
  input  wire tnt_pkg::coord_t pos_z,
  input  wire tnt_pkg::coord_t tex_u,
  input  wire tnt_pkg::coord_t tex_v,
  output logic      out_valid,
  input  wire logic out_stall,
  output tnt_pkg::coord_t normal_x,
  output tnt_pkg::coord_t normal_y,
  output tnt_pkg::coord_t normal_z,
  output tnt_pkg::coord_t tangent_x,
  output tnt_pkg::coord_t tangent_y,
  output tnt_pkg::coord_t tangent_z,
  output logic      degenerate
);
  import tnt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_RED = 4'd2, S_SQ = 4'd3,
                         S_SQRT = 4'd4, S_DIV = 4'd5, S_NEXT = 4'd6, S_OUT = 4'd7;

  logic [3:0] state;
  logic [1:0] count;
  coord_t v0 [5];
  coord_t v1 [5];
  diff_t  d1 [5];
  diff_t  d2 [5];
  prod_t  vec [8];      // normal 0..2, tangent 3..5, det 6, partial product 7
  logic [3:0] mstep;
  logic       vsel;     // 0 normal, 1 tangent
  logic [1:0] comp;
  logic [RedW-1:0] m [3];
  logic [SumW-1:0] acc;
  logic [SumW-1:0] rem_sq;
  logic [LenW-1:0] root;
  logic [5:0] it;
  logic [LenW-1:0] len;
  logic [NumW-1:0] num;
  logic [LenW:0] drem;
  logic [14:0] quo;
  coord_t res [6];
  logic       deg;
  logic       fire;
  logic       out_busy;
  logic [2:0] base;
  logic signed [OpW-1:0] ma, mb;
  logic signed [2*OpW-1:0] mp;
  logic [ProdW-1:0] mgb [3];
  logic [ProdW-1:0] big;
  logic [RedW-1:0]  red [3];
  logic [SumW+1:0] r_try;
  logic [LenW+1:0] t_try;
  logic [LenW:0]   dtrial;
  logic            q_bit;

  assign fire = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;
  assign in_stall = (state != S_IDLE) || (count == 2'd2 && out_valid);

  // Shared multiplier: squares of the reduced magnitudes in S_SQ, else the
  // cross, determinant and tangent products picked by mstep.
  always_comb begin
    ma = '0; mb = '0;
    if (state == S_SQ) begin
      ma = OpW'(m[comp]); mb = OpW'(m[comp]);
    end else begin
      unique case (mstep)
        4'd0:  begin ma = OpW'(d1[1]); mb = OpW'(d2[2]); end
        4'd1:  begin ma = OpW'(d1[2]); mb = OpW'(d2[1]); end
        4'd2:  begin ma = OpW'(d1[2]); mb = OpW'(d2[0]); end
        4'd3:  begin ma = OpW'(d1[0]); mb = OpW'(d2[2]); end
        4'd4:  begin ma = OpW'(d1[0]); mb = OpW'(d2[1]); end
        4'd5:  begin ma = OpW'(d1[1]); mb = OpW'(d2[0]); end
        4'd6:  begin ma = OpW'(d1[3]); mb = OpW'(d2[4]); end
        4'd7:  begin ma = OpW'(d1[4]); mb = OpW'(d2[3]); end
        4'd8:  begin ma = OpW'(d1[0]); mb = OpW'(d2[4]); end
        4'd9:  begin ma = OpW'(d2[0]); mb = OpW'(d1[4]); end
        4'd10: begin ma = OpW'(d1[1]); mb = OpW'(d2[4]); end
        4'd11: begin ma = OpW'(d2[1]); mb = OpW'(d1[4]); end
        4'd12: begin ma = OpW'(d1[2]); mb = OpW'(d2[4]); end
        4'd13: begin ma = OpW'(d2[2]); mb = OpW'(d1[4]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
    mp = ma * mb;
  end

  // Magnitudes of the vector being normalised and their reduction below 2^30.
  assign base = vsel ? 3'd3 : 3'd0;
  always_comb begin
    for (int i = 0; i < 3; i++)
      mgb[i] = vec[base + 3'(i)][ProdW-1] ? ProdW'(-vec[base + 3'(i)])
                                          : ProdW'(vec[base + 3'(i)]);
    big = mgb[0];
    if (mgb[1] > big) big = mgb[1];
    if (mgb[2] > big) big = mgb[2];
    for (int i = 0; i < 3; i++) begin
      priority if (big >= (ProdW'(1) << 35)) red[i] = RedW'(mgb[i] >> 6);
      else if (big >= (ProdW'(1) << 34)) red[i] = RedW'(mgb[i] >> 5);
      else if (big >= (ProdW'(1) << 33)) red[i] = RedW'(mgb[i] >> 4);
      else if (big >= (ProdW'(1) << 32)) red[i] = RedW'(mgb[i] >> 3);
      else if (big >= (ProdW'(1) << 31)) red[i] = RedW'(mgb[i] >> 2);
      else if (big >= (ProdW'(1) << 30)) red[i] = RedW'(mgb[i] >> 1);
      else red[i] = RedW'(mgb[i]);
    end
  end

  // Square-root step (two bits of acc per cycle) and divide step.
  always_comb begin
    r_try  = {rem_sq, acc[SumW-1 -: 2]};
    t_try  = {root, 2'b01};
    dtrial = {drem[LenW-1:0], num[NumW-1]};
    q_bit  = dtrial >= {1'b0, len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= 2'd0; out_valid <= 1'b0; mstep <= 4'd0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle.
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (fire) begin
          unique case (count)
            2'd0: begin
              v0[0] <= pos_x; v0[1] <= pos_y; v0[2] <= pos_z;
              v0[3] <= tex_u; v0[4] <= tex_v; count <= 2'd1;
            end
            2'd1: begin
              v1[0] <= pos_x; v1[1] <= pos_y; v1[2] <= pos_z;
              v1[3] <= tex_u; v1[4] <= tex_v; count <= 2'd2;
            end
            default: begin
              count <= 2'd0;
              d1[0] <= DiffW'(v1[0]) - DiffW'(v0[0]);
              d1[1] <= DiffW'(v1[1]) - DiffW'(v0[1]);
              d1[2] <= DiffW'(v1[2]) - DiffW'(v0[2]);
              d1[3] <= DiffW'(v1[3]) - DiffW'(v0[3]);
              d1[4] <= DiffW'(v1[4]) - DiffW'(v0[4]);
              d2[0] <= DiffW'(pos_x) - DiffW'(v0[0]);
              d2[1] <= DiffW'(pos_y) - DiffW'(v0[1]);
              d2[2] <= DiffW'(pos_z) - DiffW'(v0[2]);
              d2[3] <= DiffW'(tex_u) - DiffW'(v0[3]);
              d2[4] <= DiffW'(tex_v) - DiffW'(v0[4]);
              mstep <= 4'd0; deg <= 1'b0; state <= S_MUL;
            end
          endcase
        end
        S_MUL: begin
          // Even steps load, odd steps subtract; results land in vec.
          if (!mstep[0]) vec[7] <= ProdW'(mp);
          else begin
            unique case (mstep[3:1])
              3'd0: vec[0] <= vec[7] - ProdW'(mp);
              3'd1: vec[1] <= vec[7] - ProdW'(mp);
              3'd2: vec[2] <= vec[7] - ProdW'(mp);
              3'd3: vec[6] <= vec[7] - ProdW'(mp);
              3'd4: vec[3] <= vec[7] - ProdW'(mp);
              3'd5: vec[4] <= vec[7] - ProdW'(mp);
              default: vec[5] <= vec[7] - ProdW'(mp);
            endcase
          end
          if (mstep == 4'd13) begin
            state <= S_RED; vsel <= 1'b0;
          end
          mstep <= mstep + 4'd1;
        end
        S_RED: begin
          // Apply det sign to the tangent once, then reduce into 30 bits.
          if (!vsel && vec[6][ProdW-1]) begin
            vec[3] <= -vec[3]; vec[4] <= -vec[4]; vec[5] <= -vec[5];
          end
          if (big == '0 || (!vsel && vec[6] == '0) || (vsel && deg)) begin
            deg <= 1'b1;
            state <= vsel ? S_OUT : S_NEXT;
          end else begin
            for (int i = 0; i < 3; i++)
              m[i] <= red[i];
            acc <= '0; comp <= 2'd0; state <= S_SQ;
          end
        end
        S_SQ: begin
          acc <= acc + $unsigned(mp);
          if (comp == 2'd2) begin
            state <= S_SQRT; rem_sq <= '0; root <= '0; it <= 6'd0;
          end
          comp <= comp + 2'd1;
        end
        S_SQRT: begin
          if (r_try >= {{(SumW-LenW){1'b0}}, t_try}) begin
            rem_sq <= SumW'(r_try - {{(SumW-LenW){1'b0}}, t_try});
            root   <= {root[LenW-2:0], 1'b1};
          end else begin
            rem_sq <= SumW'(r_try);
            root   <= {root[LenW-2:0], 1'b0};
          end
          acc <= {acc[SumW-3:0], 2'b00};
          if (it == 6'd30) begin
            state <= S_DIV; comp <= 2'd0; it <= 6'd0;
          end else it <= it + 6'd1;
        end
        S_DIV: begin
          if (it == 6'd0) begin
            len  <= root;
            num  <= {2'b0, m[comp], 14'd0} + NumW'(root >> 1);
            drem <= '0; quo <= '0;
            if (root == '0) begin
              deg <= 1'b1; state <= vsel ? S_OUT : S_NEXT;
            end else it <= 6'd1;
          end else begin
            if (q_bit) begin
              drem <= dtrial - {1'b0, len}; quo <= {quo[13:0], 1'b1};
            end else begin
              drem <= dtrial; quo <= {quo[13:0], 1'b0};
            end
            num <= {num[NumW-2:0], 1'b0};
            if (it == 6'(NumW)) begin
              res[base + 3'(comp)] <=
                vec[base + 3'(comp)][ProdW-1] ? -coord_t'({quo, q_bit})
                                              :  coord_t'({quo, q_bit});
              it <= 6'd0;
              if (comp == 2'd2) state <= vsel ? S_OUT : S_NEXT;
              comp <= comp + 2'd1;
            end else it <= it + 6'd1;
          end
        end
        S_NEXT: begin
          vsel <= 1'b1; state <= S_RED;
        end
        S_OUT: if (!out_busy) begin
          out_valid <= 1'b1;
          normal_x  <= deg ? '0 : res[0];
          normal_y  <= deg ? '0 : res[1];
          normal_z  <= deg ? '0 : res[2];
          tangent_x <= deg ? '0 : res[3];
          tangent_y <= deg ? '0 : res[4];
          tangent_z <= deg ? '0 : res[5];
          degenerate <= deg;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/tnt_checker.sv -----
// Port-level checks for the triangle normal and tangent core.
// Depends on triangle_normal_tangent_core; bound to it below.
`timescale 1ns / 1ps
`default_nettype none
module tnt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic in_stall,
  input wire logic degenerate,
  input wire logic [15:0] normal_x,
  input wire logic [15:0] tangent_x
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(tangent_x)
      && $stable(degenerate)) else $error("held result lost");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 16'd0 && tangent_x == 16'd0)
    else $error("degenerate result not zeroed");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
  a_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");
endmodule
bind triangle_normal_tangent_core tnt_checker u_chk (.*);
`default_nettype wire
